// ----- rtl/core/asd_pkg.sv -----
// Shared types, constants and sensitivity tables for the shake detector.
package asd_pkg;

    // Default parameter values
    localparam int ACCEL_BITS_DEF  = 16;
    localparam int COOLDOWN_MS_DEF = 1200;

    // Filter coefficients, Q16: 0.92 and 0.08, summing to 1.0
    localparam logic [15:0] COEF_OLD   = 16'd60293;
    localparam logic [15:0] COEF_NEW   = 16'd5243;
    localparam logic [16:0] ROUND_HALF = 17'd32768;
    // 1 g in Q8 milli-g
    localparam logic [17:0] ONE_G_Q8   = 18'd256000;

    // Threshold width in Q8 milli-g
    localparam int THR_W = 19;

    // Configuration register indexes
    localparam logic [0:0] REG_SENSITIVITY    = 1'b0;
    localparam logic [0:0] REG_SENSOR_PRESENT = 1'b1;

    typedef enum logic [1:0] {
        SENS_OFF    = 2'd0,
        SENS_LOW    = 2'd1,
        SENS_MEDIUM = 2'd2,
        SENS_HIGH   = 2'd3
    } sens_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ROOT,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_FILT,
        ST_UPDATE,
        ST_PUBLISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  apply_reset;
        logic  sq_step;
        axis_t axis;
        logic  root_step;
        logic  mul_old;
        logic  mul_new;
        logic  filt_sum;
        logic  update;
        logic  publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic action;
        logic skip;
        logic out_free;
    } sts_t;

    // Deviation threshold in Q8 milli-g
    function automatic logic [THR_W-1:0] thr_q8(input sens_t sel);
        logic [THR_W-1:0] thr;
        case (sel)
            SENS_LOW:    thr = 19'd345600;
            SENS_MEDIUM: thr = 19'd230400;
            SENS_HIGH:   thr = 19'd115200;
            default:     thr = 19'd0;
        endcase
        return thr;
    endfunction

    function automatic logic [2:0] hits_needed(input sens_t sel);
        logic [2:0] n;
        case (sel)
            SENS_LOW:    n = 3'd6;
            SENS_MEDIUM: n = 3'd4;
            SENS_HIGH:   n = 3'd2;
            default:     n = 3'd7;
        endcase
        return n;
    endfunction

    // Window length in ms
    function automatic logic [9:0] window_ms(input sens_t sel);
        logic [9:0] w;
        case (sel)
            SENS_LOW:    w = 10'd450;
            SENS_MEDIUM: w = 10'd650;
            SENS_HIGH:   w = 10'd900;
            default:     w = 10'd1;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/asd_ctrl.sv -----
// Sequencer for the shake detector: steps the datapath through one sample.
module asd_ctrl #(
    parameter int ACCEL_BITS = asd_pkg::ACCEL_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  asd_pkg::sts_t sts,
    output asd_pkg::cmd_t cmd
);

    localparam int CNT_W = (ACCEL_BITS > 1) ? $clog2(ACCEL_BITS) : 1;

    asd_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // State and root step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != asd_pkg::ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = asd_pkg::AXIS_X;
        case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = asd_pkg::ST_CHECK;
                end
            end
            asd_pkg::ST_CHECK:
            begin
                if (sts.action)
                begin
                    cmd.apply_reset = 1'b1;
                    state_next      = asd_pkg::ST_PUBLISH;
                end
                else if (sts.skip)
                    state_next = asd_pkg::ST_PUBLISH;
                else
                    state_next = asd_pkg::ST_SQ_X;
            end
            asd_pkg::ST_SQ_X:
            begin
                cmd.sq_step = 1'b1;
                cmd.axis    = asd_pkg::AXIS_X;
                state_next  = asd_pkg::ST_SQ_Y;
            end
            asd_pkg::ST_SQ_Y:
            begin
                cmd.sq_step = 1'b1;
                cmd.axis    = asd_pkg::AXIS_Y;
                state_next  = asd_pkg::ST_SQ_Z;
            end
            asd_pkg::ST_SQ_Z:
            begin
                cmd.sq_step = 1'b1;
                cmd.axis    = asd_pkg::AXIS_Z;
                cnt_next    = CNT_W'(ACCEL_BITS - 1);
                state_next  = asd_pkg::ST_ROOT;
            end
            asd_pkg::ST_ROOT:
            begin
                // one root bit per cycle
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = asd_pkg::ST_MUL_OLD;
            end
            asd_pkg::ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = asd_pkg::ST_MUL_NEW;
            end
            asd_pkg::ST_MUL_NEW:
            begin
                cmd.mul_new = 1'b1;
                state_next  = asd_pkg::ST_FILT;
            end
            asd_pkg::ST_FILT:
            begin
                cmd.filt_sum = 1'b1;
                state_next   = asd_pkg::ST_UPDATE;
            end
            asd_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = asd_pkg::ST_PUBLISH;
            end
            asd_pkg::ST_PUBLISH:
            begin
                // wait for room in the output register
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = asd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = asd_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/asd_datapath.sv -----
// Datapath: sample capture, squares, bit-serial square root, filter and hit logic.
module asd_datapath #(
    parameter int ACCEL_BITS  = asd_pkg::ACCEL_BITS_DEF,
    parameter int COOLDOWN_MS = asd_pkg::COOLDOWN_MS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input beat
    input  logic                  action,
    input  logic [ACCEL_BITS-1:0] accel_x,
    input  logic [ACCEL_BITS-1:0] accel_y,
    input  logic [ACCEL_BITS-1:0] accel_z,
    input  logic [31:0]           now_ms,
    input  logic [31:0]           reset_cooldown_ms,
    // configuration
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [1:0]            cfg_data,
    // result beat
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  shake,
    // control
    input  asd_pkg::cmd_t         cmd,
    output asd_pkg::sts_t         sts
);

    localparam int F_W    = ACCEL_BITS + 10;
    localparam int SQ_W   = 2 * ACCEL_BITS;
    localparam int MB_W   = (ACCEL_BITS > 16) ? ACCEL_BITS : 16;
    localparam int PROD_W = F_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int MAG_W  = ACCEL_BITS + 8;
    localparam int REM_W  = ACCEL_BITS + 2;
    localparam int DEV_W  = (F_W > asd_pkg::THR_W) ? F_W : asd_pkg::THR_W;

    // Captured beat
    logic                  action_reg;
    logic [ACCEL_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic [31:0]           now_reg, rcd_reg;

    // Working registers
    logic [SQ_W-1:0]       sq_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ACCEL_BITS-1:0] root_reg;
    logic [ACC_W-1:0]      acc_reg;

    // Detector state and configuration
    asd_pkg::sens_t        sens_reg;
    logic                  present_reg;
    logic [F_W-1:0]        filt_reg;
    logic [31:0]           ws_reg;
    logic                  open_reg;
    logic [2:0]            hits_reg;
    logic [31:0]           cd_reg;
    logic                  shake_reg;
    logic                  out_valid_reg;
    logic                  shake_out_reg;

    // Axis select and absolute value
    logic [ACCEL_BITS-1:0] axis_val, abs_val;
    always_comb
    begin
        case (cmd.axis)
            asd_pkg::AXIS_X: axis_val = ax_reg;
            asd_pkg::AXIS_Y: axis_val = ay_reg;
            asd_pkg::AXIS_Z: axis_val = az_reg;
            default:         axis_val = ax_reg;
        endcase
        abs_val = axis_val[ACCEL_BITS-1] ? (~axis_val + 1'b1) : axis_val;
    end

    // Shared multiplier
    logic [MAG_W-1:0]  mag_q8;
    logic [F_W-1:0]    mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod;
    assign mag_q8 = {root_reg, 8'b0};
    always_comb
    begin
        if (cmd.mul_old)
        begin
            mul_a = filt_reg;
            mul_b = MB_W'(asd_pkg::COEF_OLD);
        end
        else if (cmd.mul_new)
        begin
            mul_a = F_W'(mag_q8);
            mul_b = MB_W'(asd_pkg::COEF_NEW);
        end
        else
        begin
            mul_a = F_W'(abs_val);
            mul_b = MB_W'(abs_val);
        end
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Restoring square root step
    logic [REM_W+1:0] rem_sh, trial;
    logic             root_fit;
    assign rem_sh   = {rem_reg, sq_reg[SQ_W-1 -: 2]};
    assign trial    = (REM_W + 2)'({root_reg, 2'b01});
    assign root_fit = (rem_sh >= trial);

    // Filter rounding
    logic [ACC_W-1:0] acc_round;
    assign acc_round = acc_reg + ACC_W'(asd_pkg::ROUND_HALF);

    // Deviation, window and hit decision
    logic [F_W-1:0]   mag_ext, dev;
    logic             hit, new_win, detect;
    logic [31:0]      elapsed;
    logic [2:0]       hits_base, hits_inc;
    assign mag_ext   = F_W'(mag_q8);
    assign dev       = (mag_ext >= filt_reg) ? (mag_ext - filt_reg) : (filt_reg - mag_ext);
    assign hit       = (DEV_W'(dev) >= DEV_W'(asd_pkg::thr_q8(sens_reg)));
    assign elapsed   = now_reg - ws_reg;
    assign new_win   = !open_reg || (elapsed > 32'(asd_pkg::window_ms(sens_reg)));
    assign hits_base = new_win ? 3'd0 : hits_reg;
    assign hits_inc  = hits_base + {2'b0, hit};
    assign detect    = (hits_inc >= asd_pkg::hits_needed(sens_reg));

    // Status
    assign sts.action   = action_reg;
    assign sts.skip     = !present_reg || (now_reg < cd_reg) || (sens_reg == asd_pkg::SENS_OFF);
    assign sts.out_free = !out_valid_reg || !out_stall;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            ax_reg     <= accel_x;
            ay_reg     <= accel_y;
            az_reg     <= accel_z;
            now_reg    <= now_ms;
            rcd_reg    <= reset_cooldown_ms;
            sq_reg     <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sq_step)
            sq_reg <= sq_reg + SQ_W'(prod);
        else if (cmd.root_step)
        begin
            sq_reg <= sq_reg << 2;
            if (root_fit)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ACCEL_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ACCEL_BITS-2:0], 1'b0};
            end
        end

        if (cmd.mul_old)
            acc_reg <= ACC_W'(prod);
        else if (cmd.mul_new)
            acc_reg <= acc_reg + ACC_W'(prod);

        if (cmd.publish)
            shake_out_reg <= shake_reg;
    end

    // Detector state, configuration and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg      <= asd_pkg::SENS_LOW;
            present_reg   <= 1'b0;
            filt_reg      <= F_W'(asd_pkg::ONE_G_Q8);
            ws_reg        <= '0;
            open_reg      <= 1'b0;
            hits_reg      <= '0;
            cd_reg        <= '0;
            shake_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    asd_pkg::REG_SENSITIVITY:    sens_reg    <= asd_pkg::sens_t'(cfg_data);
                    asd_pkg::REG_SENSOR_PRESENT: present_reg <= cfg_data[0];
                    default:                     present_reg <= present_reg;
                endcase
            end

            if (cmd.capture)
                shake_reg <= 1'b0;

            if (cmd.apply_reset)
            begin
                filt_reg <= F_W'(asd_pkg::ONE_G_Q8);
                ws_reg   <= '0;
                open_reg <= 1'b0;
                hits_reg <= '0;
                cd_reg   <= now_reg + rcd_reg;
            end

            if (cmd.filt_sum)
                filt_reg <= F_W'(acc_round >> 16);

            if (cmd.update)
            begin
                if (detect)
                begin
                    ws_reg    <= '0;
                    open_reg  <= 1'b0;
                    hits_reg  <= '0;
                    cd_reg    <= now_reg + 32'(COOLDOWN_MS);
                    shake_reg <= 1'b1;
                end
                else
                begin
                    if (new_win)
                        ws_reg <= now_reg;
                    open_reg <= 1'b1;
                    hits_reg <= hits_inc;
                end
            end

            // output register: set on publish, cleared when the beat is taken
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign shake     = shake_out_reg;

endmodule

// ----- rtl/core/accel_shake_detector_unit.sv -----
// Shake detector: one result beat for each accepted sample beat. The bit-serial square
// root (one bit per cycle) is the longest step; squares and filter products share one
// multiplier. Reset actions and skipped samples go straight to the result beat.
// One sample is in work at a time; the next is taken as soon as the result is registered.
// rst_n (asynchronous, active low) restores sensitivity low, sensor absent, filter 1 g,
// no window open, no hits and no cooldown.
module accel_shake_detector_unit #(
    parameter int ACCEL_BITS  = asd_pkg::ACCEL_BITS_DEF,
    parameter int COOLDOWN_MS = asd_pkg::COOLDOWN_MS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [ACCEL_BITS-1:0] accel_x,
    input  logic [ACCEL_BITS-1:0] accel_y,
    input  logic [ACCEL_BITS-1:0] accel_z,
    input  logic [31:0]           now_ms,
    input  logic [31:0]           reset_cooldown_ms,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  shake,
    // configuration
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [1:0]            cfg_data
);

    asd_pkg::cmd_t cmd;
    asd_pkg::sts_t sts;

    // Sequencer
    asd_ctrl #(
        .ACCEL_BITS (ACCEL_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and detector state
    asd_datapath #(
        .ACCEL_BITS  (ACCEL_BITS),
        .COOLDOWN_MS (COOLDOWN_MS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .action            (action),
        .accel_x           (accel_x),
        .accel_y           (accel_y),
        .accel_z           (accel_z),
        .now_ms            (now_ms),
        .reset_cooldown_ms (reset_cooldown_ms),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .shake             (shake),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the shake detector: directed table, random sample sequences, scoreboard.
module tb_top;
    import asd_pkg::*;

    localparam int AB          = ACCEL_BITS_DEF;
    localparam int DUT_LAT     = AB + 10;
    localparam int RAND_BEATS  = 1700;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // One row of the directed table: a sample beat or a register write
    typedef struct packed {
        row_kind_t     kind;
        logic          act;
        logic [AB-1:0] x, y, z;
        logic [31:0]   t, cool;
        logic          typed;
        logic          shake;
        logic [0:0]    idx;
        logic [1:0]    data;
    } dir_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          action = 1'b0;
    logic [AB-1:0] accel_x = '0;
    logic [AB-1:0] accel_y = '0;
    logic [AB-1:0] accel_z = '0;
    logic [31:0]   now_ms = '0;
    logic [31:0]   reset_cooldown_ms = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          shake;
    logic          cfg_we = 1'b0;
    logic [0:0]    cfg_index = '0;
    logic [1:0]    cfg_data = '0;

    // Detector state as the bench predicts it
    sens_t       det_sens = SENS_LOW;
    logic        det_present = 1'b0;
    logic [63:0] det_filt = 64'(ONE_G_Q8);
    logic [31:0] det_win_start = '0;
    logic        det_win_open = 1'b0;
    logic [2:0]  det_hits = '0;
    logic [31:0] det_cool_until = '0;

    // Shake flags owed by the block, oldest first
    logic shake_due[$];

    int  beats_sent = 0;
    int  resets_sent = 0;
    int  shakes_due = 0;
    int  cfg_writes = 0;
    int  results_seen = 0;
    int  bad_count = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    dir_row_t dir_tab [29] = '{
        // sensor absent after reset: nothing detected, reset action passes
        '{ROW_BEAT, 1'b0, 16'h7FFF, 16'h8000, 16'h0000, 32'd100, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'd200, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSOR_PRESENT, 2'd1},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSITIVITY, SENS_OFF},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd300, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSITIVITY, SENS_HIGH},
        // at rest, then two full-scale hits make a shake
        '{ROW_BEAT, 1'b0, 16'h0000, 16'h0000, 16'h03E8, 32'd1000, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd1010, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd1020, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        // inside the cooldown, then exactly at its end
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd1500, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'd2220, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        // reset action whose cooldown end wraps; window spanning the time wrap
        '{ROW_BEAT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FF00, 32'h110,
          1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FF10, 32'd0,
          1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h50, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h60, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h1000, 32'hFFFF_FFFF,
          1'b1, 1'b0, 1'b0, 2'd0},
        // window length: one past it restarts, exactly on it still counts
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h2000, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h2385, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h2709, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSITIVITY, SENS_LOW},
        '{ROW_BEAT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h3000, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h0001, 16'hFFFF, 16'h0001, 32'h3010, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        // long cooldown from a reset action, cleared by a zero-length one
        '{ROW_BEAT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h4000, 32'hFFFF_0000,
          1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h5000, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_BEAT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h5000, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSITIVITY,
          SENS_MEDIUM},
        '{ROW_BEAT, 1'b0, 16'h7FFF, 16'h0000, 16'h8000, 32'h5000, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0},
        '{ROW_CFG, 1'b0, 16'h0, 16'h0, 16'h0, 32'd0, 32'd0, 1'b0, 1'b0, REG_SENSOR_PRESENT, 2'd0},
        '{ROW_BEAT, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h5100, 32'd0, 1'b1, 1'b0, 1'b0, 2'd0}
    };

    accel_shake_detector_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .accel_x           (accel_x),
        .accel_y           (accel_y),
        .accel_z           (accel_z),
        .now_ms            (now_ms),
        .reset_cooldown_ms (reset_cooldown_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .shake             (shake),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    // Floor square root, one result bit at a time from the top
    function automatic logic [16:0] floor_root(input logic [63:0] n);
        logic [16:0] r;
        logic [16:0] c;
        r = '0;
        for (int b = 16; b >= 0; b--)
        begin
            c = r | (17'd1 << b);
            if (64'(c) * 64'(c) <= n)
                r = c;
        end
        return r;
    endfunction

    // Advance the predicted detector by one beat; returns the shake flag
    function automatic logic detect_step(input logic act,
                                         input logic signed [AB-1:0] x, y, z,
                                         input logic [31:0] t, cool);
        longint      sx, sy, sz;
        logic [63:0] mag_q8, dev, limit_mg;
        logic [31:0] win_len;
        logic [2:0]  need;
        if (act)
        begin
            det_filt       = 64'(ONE_G_Q8);
            det_win_start  = '0;
            det_win_open   = 1'b0;
            det_hits       = '0;
            det_cool_until = t + cool;
            return 1'b0;
        end
        if (!det_present || t < det_cool_until || det_sens == SENS_OFF)
            return 1'b0;
        case (det_sens)
            SENS_LOW:
            begin
                limit_mg = 64'd1350;
                need     = 3'd6;
                win_len  = 32'd450;
            end
            SENS_MEDIUM:
            begin
                limit_mg = 64'd900;
                need     = 3'd4;
                win_len  = 32'd650;
            end
            default:
            begin
                limit_mg = 64'd450;
                need     = 3'd2;
                win_len  = 32'd900;
            end
        endcase
        sx = x;
        sy = y;
        sz = z;
        mag_q8   = 64'(floor_root(64'(sx * sx + sy * sy + sz * sz))) << 8;
        det_filt = (det_filt * 64'(COEF_OLD) + mag_q8 * 64'(COEF_NEW)
                    + 64'(ROUND_HALF)) >> 16;
        dev = (mag_q8 >= det_filt) ? mag_q8 - det_filt : det_filt - mag_q8;
        // open a fresh window when none is open or the old one has run out
        if (!det_win_open || (t - det_win_start) > win_len)
        begin
            det_win_start = t;
            det_win_open  = 1'b1;
            det_hits      = '0;
        end
        if (dev >= limit_mg * 64'd256)
            det_hits = det_hits + 3'd1;
        if (det_hits >= need)
        begin
            det_win_start  = '0;
            det_win_open   = 1'b0;
            det_hits       = '0;
            det_cool_until = t + 32'(COOLDOWN_MS_DEF);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Idle length between beats: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [AB-1:0] axis_shake();
        int v;
        v = $urandom_range(1200, 32767);
        if ($urandom_range(0, 1))
            v = -v;
        return AB'(v);
    endfunction

    function automatic logic [AB-1:0] axis_rest(input int centre);
        return AB'(centre + int'($urandom_range(0, 120)) - 60);
    endfunction

    // Register write, only once the block has drained
    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        in_valid <= 1'b0;
        while (shake_due.size() != 0)
            @(posedge clk);
        repeat (DUT_LAT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SENSITIVITY)
            det_sens = sens_t'(val);
        else
            det_present = val[0];
        cfg_writes++;
    endtask

    // Offer one sample beat and hold it until taken; then book its result
    task automatic send_beat(input logic act, input logic [AB-1:0] x, y, z,
                             input logic [31:0] t, cool, input int gap,
                             input logic typed, input logic typed_shake);
        logic want;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        action            <= act;
        accel_x           <= x;
        accel_y           <= y;
        accel_z           <= z;
        now_ms            <= t;
        reset_cooldown_ms <= cool;
        do
            @(posedge clk);
        while (in_stall);
        want = detect_step(act, x, y, z, t, cool);
        shake_due.push_back(typed ? typed_shake : want);
        beats_sent++;
        if (act)
            resets_sent++;
        if (typed ? typed_shake : want)
            shakes_due++;
    endtask

    task automatic report_bad(input string what, input logic want, input logic got);
        if (bad_count < MAX_SHOWN)
            $display("tb_top: result %0d: %s, expected shake %b, got %b",
                     results_seen, what, want, got);
        bad_count++;
    endtask

    // Scoreboard: each taken result beat against the oldest owed flag
    always @(posedge clk)
    begin : result_check
        logic want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (shake_due.size() == 0)
            begin
                report_bad("no result owed", 1'bx, shake);
            end
            else
            begin
                want = shake_due.pop_front();
                if (shake !== want)
                    report_bad("shake mismatch", want, shake);
            end
            results_seen++;
        end
    end

    // Result side: random stall runs, one long hold-off on request
    initial
    begin : result_sink
        int stall_len;
        int flow_len;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0:       stall_len = $urandom_range(15, 50);
                1, 2, 3: stall_len = 0;
                default: stall_len = $urandom_range(1, 3);
            endcase
            flow_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (flow_len) @(posedge clk);
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        sens_t       sens;
        logic        present;
        logic [31:0] tick;
        int          quota;
        int          n;
        int          len;
        int          kind;
        int          rand_base;
        bit          no_gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            else
                send_beat(dir_tab[i].act, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                          dir_tab[i].t, dir_tab[i].cool, idle_len(),
                          dir_tab[i].typed, dir_tab[i].shake);
        end

        rand_base = beats_sent;
        for (int p = 0; beats_sent - rand_base < RAND_BEATS; p++)
        begin
            case (p)
                0:       sens = SENS_HIGH;
                1:       sens = SENS_LOW;
                2:       sens = SENS_MEDIUM;
                3:       sens = SENS_OFF;
                default: sens = sens_t'($urandom_range(0, 3));
            endcase
            // the hold-off phase keeps the sensor present so beats stay long
            if (p == 5)
                present = 1'b0;
            else if (p == 1)
                present = 1'b1;
            else
                present = ($urandom_range(0, 7) != 0);
            write_reg(REG_SENSITIVITY, sens);
            write_reg(REG_SENSOR_PRESENT, {1'b0, present});
            quota  = (sens == SENS_OFF || !present) ? 40 : $urandom_range(150, 250);
            if (quota > RAND_BEATS - (beats_sent - rand_base))
                quota = RAND_BEATS - (beats_sent - rand_base);
            no_gap = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       tick = $urandom_range(0, 5000);
                1:       tick = $urandom();
                default: tick = 32'hFFFF_F000 + $urandom_range(0, 3000);
            endcase
            if (p == 1)
                hold_req = 1'b1;
            // replace any stale cooldown with a fresh one from a reset action
            send_beat(1'b1, '0, '0, '0, tick, $urandom_range(0, 300),
                      no_gap ? 0 : idle_len(), 1'b0, 1'b0);
            n = 1;
            while (n < quota)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 45)
                begin
                    // shake burst; now and then spaced out past the window
                    len = $urandom_range(2, 8);
                    repeat (len)
                    begin
                        tick += ($urandom_range(0, 5) == 0) ? $urandom_range(300, 1300)
                                                            : $urandom_range(5, 120);
                        send_beat(1'b0, axis_shake(), axis_shake(), axis_shake(), tick, '0,
                                  no_gap ? 0 : idle_len(), 1'b0, 1'b0);
                    end
                    n += len;
                end
                else if (kind < 80)
                begin
                    // device at rest, about 1 g on z
                    len = $urandom_range(3, 12);
                    repeat (len)
                    begin
                        tick += $urandom_range(5, 60);
                        send_beat(1'b0, axis_rest(0), axis_rest(0), axis_rest(1000), tick,
                                  '0, no_gap ? 0 : idle_len(), 1'b0, 1'b0);
                    end
                    n += len;
                end
                else if (kind < 92)
                begin
                    // noise: any field value, sometimes a jump in time
                    if ($urandom_range(0, 3) == 0)
                        tick = $urandom();
                    else
                        tick += $urandom_range(0, 200);
                    send_beat(1'b0, AB'($urandom()), AB'($urandom()), AB'($urandom()), tick,
                              $urandom(), no_gap ? 0 : idle_len(), 1'b0, 1'b0);
                    n++;
                end
                else
                begin
                    tick += $urandom_range(0, 100);
                    send_beat(1'b1, AB'($urandom()), AB'($urandom()), AB'($urandom()), tick,
                              ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500),
                              no_gap ? 0 : idle_len(), 1'b0, 1'b0);
                    n++;
                end
            end
        end

        // drain and let the block settle
        in_valid <= 1'b0;
        while (shake_due.size() != 0)
            @(posedge clk);
        repeat (DUT_LAT) @(posedge clk);
        $display("tb_top: %0d sample beats incl. %0d reset actions, %0d shakes, %0d reg writes",
                 beats_sent, resets_sent, shakes_due, cfg_writes);
        $display("tb_top: %0d results checked, %0d mismatches, one %0d-cycle receiver hold",
                 results_seen, bad_count, HOLD_CYCLES);
        if (bad_count == 0 && shake_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- accel_shake_detector_unit.f -----
rtl/core/asd_pkg.sv
rtl/core/asd_ctrl.sv
rtl/core/asd_datapath.sv
rtl/core/accel_shake_detector_unit.sv
bench/tb_top.sv
